/* rtl/nls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_pkg
// shared types and constants for the number literal scanner
// ----------------------------------------------------------------------------
package nls_pkg;

   // character codes the scanner looks for
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_ONE        = 8'h31;
   localparam logic [7:0] CH_TWO        = 8'h32;
   localparam logic [7:0] CH_SEVEN      = 8'h37;
   localparam logic [7:0] CH_EIGHT      = 8'h38;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_F    = 8'h46;
   localparam logic [7:0] CH_LOWER_B    = 8'h62;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;
   localparam logic [7:0] CH_LOWER_P    = 8'h70;
   localparam logic [7:0] CH_UPPER_S    = 8'h53;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;

   // radix codes as they appear on the result
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_BIN = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   localparam logic KIND_INT   = 1'b0;
   localparam logic KIND_FLOAT = 1'b1;

   // character classes produced by the front end
   typedef enum logic [3:0] {
      CLS_ZERO,
      CLS_ONE,
      CLS_OCT,        // 2 to 7
      CLS_DEC_HI,     // 8 and 9
      CLS_HEX_AF,     // uppercase A to F
      CLS_B,
      CLS_UNDERSCORE,
      CLS_X,
      CLS_P,
      CLS_S,
      CLS_DOT,
      CLS_SIGN,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_ZERO,
      MODE_BIN,
      MODE_DEC_INT,
      MODE_DEC_FRAC,
      MODE_DEC_ESIGN,
      MODE_DEC_EXP,
      MODE_PFX_INT,
      MODE_PFX_FRAC,
      MODE_PFX_ESIGN,
      MODE_PFX_EXP,
      MODE_SUFFIXED
   } scan_mode_type;

   // one classified byte as it travels through the queue
   typedef struct packed {
      logic           start;
      char_class_type cls;
   } qentry_type;

   // queue status seen by the front end and the back end
   typedef struct packed {
      logic       full;
      logic       valid;
      qentry_type head;
   } qstat_type;

endpackage

/* rtl/number_literal_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_literal_scanner_top
// scans numeric literals from a byte stream, while the queue has room one byte per cycle
// ----------------------------------------------------------------------------
// Feed source bytes on req_ch, raising req_start_req on the first byte of a
// literal. The block takes one byte per cycle while the byte queue is not
// full, and gives one result item per literal (kind, radix, length,
// too_long) when the first byte that does not belong to it arrives, or when
// a new start byte arrives. That ending byte is not counted. The byte that
// ends the literal is written into the byte queue, then the back end loads
// the result register and raises rsp_valid; a result still waiting to be
// taken holds the back end. Throughput is set by the back end state
// machine, which takes one queued byte per cycle whenever the result
// register is free or being taken.
// ----------------------------------------------------------------------------
module number_literal_scanner_top #(
   parameter int MAX_LENGTH  = 255,  // saturation point of the byte count, 15 to 65535
   parameter int QUEUE_DEPTH = 4     // entries between front and back end
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_start_req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_token_kind,
   output logic [1:0] rsp_radix,
   output logic [7:0] rsp_length,
   output logic       rsp_too_long
);
   import nls_pkg::*;

   // front to queue
   logic       push;
   qentry_type push_entry;
   // queue to back end
   qstat_type  stat;
   logic       pop;

   // front end: classify each byte into a small class code
   nls_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_start_req (req_start_req),
      .queue_full    (stat.full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // queue lets the front keep taking bytes while the result side stalls
   nls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .stat       (stat)
   );

   // back end: literal state machine plus registered result
   nls_back #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .stat           (stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_radix      (rsp_radix),
      .rsp_length     (rsp_length),
      .rsp_too_long   (rsp_too_long)
   );

endmodule

/* rtl/nls_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_front
// accepts bytes and sorts each into a character class for the queue
// ----------------------------------------------------------------------------
module nls_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_ch,
   input  logic                req_start_req,
   input  logic                queue_full,
   output logic                push,
   output nls_pkg::qentry_type push_entry
);
   import nls_pkg::*;

   char_class_type cls;

   always_comb begin
      if (req_ch == CH_ZERO) begin
         cls = CLS_ZERO;
      end else if (req_ch == CH_ONE) begin
         cls = CLS_ONE;
      end else if (req_ch inside {[CH_TWO:CH_SEVEN]}) begin
         cls = CLS_OCT;
      end else if (req_ch inside {[CH_EIGHT:CH_NINE]}) begin
         cls = CLS_DEC_HI;
      end else if (req_ch inside {[CH_UPPER_A:CH_UPPER_F]}) begin
         cls = CLS_HEX_AF;
      end else if (req_ch == CH_LOWER_B) begin
         cls = CLS_B;
      end else if (req_ch == CH_UNDERSCORE) begin
         cls = CLS_UNDERSCORE;
      end else if (req_ch == CH_LOWER_X) begin
         cls = CLS_X;
      end else if (req_ch == CH_LOWER_P) begin
         cls = CLS_P;
      end else if (req_ch == CH_UPPER_S) begin
         cls = CLS_S;
      end else if (req_ch == CH_DOT) begin
         cls = CLS_DOT;
      end else if (req_ch inside {CH_PLUS, CH_MINUS}) begin
         cls = CLS_SIGN;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign req_ready        = !queue_full;
   assign push             = req_valid && !queue_full;
   assign push_entry.start = req_start_req;
   assign push_entry.cls   = cls;

endmodule

/* rtl/nls_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_queue
// short first-in first-out queue of classified bytes
// ----------------------------------------------------------------------------
module nls_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nls_pkg::qentry_type push_entry,
   input  logic                pop,
   output nls_pkg::qstat_type  stat
);
   import nls_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qentry_type          slot_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.valid = (count_ff != '0);
   assign stat.head  = slot_ff[rd_ptr_ff];

endmodule

/* rtl/nls_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_back
// literal state machine and result register
// ----------------------------------------------------------------------------
module nls_back #(
   parameter int MAX_LENGTH = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  nls_pkg::qstat_type stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_token_kind,
   output logic [1:0]         rsp_radix,
   output logic [7:0]         rsp_length,
   output logic               rsp_too_long
);
   import nls_pkg::*;

   localparam int CW = $clog2(MAX_LENGTH + 1);

   scan_mode_type  mode_ff, mode_in;
   logic [1:0]     radix_ff, radix_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           kind_ff, kind_in;
   logic [1:0]     rsp_radix_ff, rsp_radix_in;
   logic [7:0]     length_ff, length_in;
   logic           too_long_ff, too_long_in;

   logic           start;
   char_class_type cls;
   logic           is_dec, is_oct, is_rdig;
   scan_mode_type  begin_mode, step_mode;
   logic [1:0]     step_radix;
   logic           emit;
   logic           cur_float;
   logic [7:0]     cur_length;

   assign start = stat.head.start;
   assign cls   = stat.head.cls;
   assign pop   = stat.valid && (!rsp_valid_ff || rsp_ready);

   assign is_oct  = (cls inside {CLS_ZERO, CLS_ONE, CLS_OCT});
   assign is_dec  = is_oct || (cls == CLS_DEC_HI);
   assign is_rdig = (radix_ff == RADIX_HEX) ? (is_dec || cls == CLS_HEX_AF) : is_oct;

   // mode for a byte that opens a literal
   always_comb begin
      case (cls)
         CLS_ZERO:                     begin_mode = MODE_ZERO;
         CLS_ONE, CLS_OCT, CLS_DEC_HI: begin_mode = MODE_DEC_INT;
         CLS_DOT:                      begin_mode = MODE_DEC_FRAC;
         default:                      begin_mode = MODE_IDLE;
      endcase
   end

   // transition for a byte inside a literal, idle means it ends the literal
   always_comb begin
      step_mode  = MODE_IDLE;
      step_radix = radix_ff;
      case (mode_ff)
         MODE_ZERO: begin
            if (cls == CLS_B) begin
               step_mode  = MODE_BIN;
               step_radix = RADIX_BIN;
            end else if (cls == CLS_UNDERSCORE) begin
               step_mode  = MODE_PFX_INT;
               step_radix = RADIX_OCT;
            end else if (cls == CLS_X) begin
               step_mode  = MODE_PFX_INT;
               step_radix = RADIX_HEX;
            end else if (is_dec) begin
               step_mode = MODE_DEC_INT;
            end else if (cls == CLS_DOT) begin
               step_mode = MODE_DEC_FRAC;
            end
         end
         MODE_BIN: begin
            if (cls inside {CLS_ZERO, CLS_ONE}) step_mode = MODE_BIN;
         end
         MODE_DEC_INT: begin
            if (is_dec)              step_mode = MODE_DEC_INT;
            else if (cls == CLS_DOT) step_mode = MODE_DEC_FRAC;
         end
         MODE_DEC_FRAC: begin
            if (is_dec)            step_mode = MODE_DEC_FRAC;
            else if (cls == CLS_P) step_mode = MODE_DEC_ESIGN;
         end
         MODE_DEC_ESIGN: begin
            if (cls == CLS_SIGN || is_oct) step_mode = MODE_DEC_EXP;
         end
         MODE_DEC_EXP: begin
            if (is_oct) step_mode = MODE_DEC_EXP;
         end
         MODE_PFX_INT: begin
            if (is_rdig)             step_mode = MODE_PFX_INT;
            else if (cls == CLS_DOT) step_mode = MODE_PFX_FRAC;
            else if (cls == CLS_P)   step_mode = MODE_PFX_ESIGN;
            else if (cls == CLS_S)   step_mode = MODE_SUFFIXED;
         end
         MODE_PFX_FRAC: begin
            if (is_rdig)           step_mode = MODE_PFX_FRAC;
            else if (cls == CLS_P) step_mode = MODE_PFX_ESIGN;
         end
         MODE_PFX_ESIGN: begin
            if (cls == CLS_SIGN || is_rdig) step_mode = MODE_PFX_EXP;
         end
         MODE_PFX_EXP: begin
            if (is_rdig) step_mode = MODE_PFX_EXP;
         end
         default: begin
            step_mode = MODE_IDLE;
         end
      endcase
   end

   // next state of the scanner
   always_comb begin
      mode_in  = mode_ff;
      radix_in = radix_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (pop) begin
         if (start) begin
            mode_in  = begin_mode;
            radix_in = RADIX_DEC;
            count_in = (begin_mode != MODE_IDLE) ? CW'(1) : '0;
            ovf_in   = 1'b0;
         end else if (mode_ff != MODE_IDLE) begin
            if (step_mode == MODE_IDLE) begin
               mode_in  = MODE_IDLE;
               radix_in = RADIX_DEC;
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               mode_in  = step_mode;
               radix_in = step_radix;
               if (32'(count_ff) < 32'(MAX_LENGTH)) count_in = count_ff + CW'(1);
               else                                 ovf_in   = 1'b1;
            end
         end
      end
   end

   // result outputs; the idle state holds zeros, which is the empty literal
   assign cur_float = (mode_ff inside {MODE_DEC_FRAC, MODE_DEC_ESIGN, MODE_DEC_EXP,
                                       MODE_PFX_FRAC, MODE_PFX_ESIGN, MODE_PFX_EXP});
   assign cur_length = (32'(count_ff) > 32'd255) ? 8'hFF : 8'(count_ff);

   always_comb begin
      emit = 1'b0;
      if (pop) begin
         if (mode_ff == MODE_IDLE) emit = start && (begin_mode == MODE_IDLE);
         else                      emit = start || (step_mode == MODE_IDLE);
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      rsp_radix_in = rsp_radix_ff;
      length_in    = length_ff;
      too_long_in  = too_long_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = cur_float ? KIND_FLOAT : KIND_INT;
         rsp_radix_in = radix_ff;
         length_in    = cur_length;
         too_long_in  = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         radix_ff     <= RADIX_DEC;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         radix_ff     <= radix_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      rsp_radix_ff <= rsp_radix_in;
      length_ff    <= length_in;
      too_long_ff  <= too_long_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_token_kind = kind_ff;
   assign rsp_radix      = rsp_radix_ff;
   assign rsp_length     = length_ff;
   assign rsp_too_long   = too_long_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the number literal scanner
// ----------------------------------------------------------------------------
// Bytes go in on the req channel and literal descriptions come back on the
// rsp channel, both valid/ready. A behavioral scanner in this file follows
// every accepted item and queues the literal result it expects. The rsp
// monitor compares each accepted result field by field with the oldest entry
// in that queue. Stimulus is a directed set of corner literals, a set of
// literals around the length saturation point, and a long random stream of
// well-formed literals with corrupted bytes, noise and overlapping starts,
// run with and without idle gaps and back pressure.
// ----------------------------------------------------------------------------
module tb;
   import nls_pkg::*;

   localparam int LIT_MAX = 255;            // saturation point of the byte count
   localparam int SETTLE_CYCLES = 10;       // queue plus result register, with margin
   localparam int RANDOM_BYTES = 760;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // one result item as it leaves the block
   typedef struct packed {
      logic       kind;
      logic [1:0] radix;
      logic [7:0] length;
      logic       too_long;
   } literal_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       req_start_req = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_token_kind;
   logic [1:0] rsp_radix;
   logic [7:0] rsp_length;
   logic       rsp_too_long;

   // literal results still owed by the block, oldest first
   literal_result_type expected_literals[$];
   literal_result_type want_lit;
   int error_count = 0;
   int bytes_scanned = 0;       // items that the scanner did not simply ignore

   // idling controls
   bit source_gaps = 1'b0;
   bit sink_stalls = 1'b0;
   int stall_left = 0;
   int sink_pick;

   // behavioral copy of the scanner state
   scan_mode_type lit_mode = MODE_IDLE;
   logic [1:0]    lit_radix = RADIX_DEC;
   int            lit_count = 0;
   logic          lit_over = 1'b0;

   number_literal_scanner_top #(
      .MAX_LENGTH(LIT_MAX)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_token_kind(rsp_token_kind),
      .rsp_radix(rsp_radix),
      .rsp_length(rsp_length),
      .rsp_too_long(rsp_too_long)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // scanner prediction
   // ---------------------------------------------------------------------------

   function automatic bit is_dec_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_oct_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_SEVEN;
   endfunction

   // digit of the current prefixed radix: hex takes uppercase A-F only
   function automatic bit is_radix_digit(input logic [7:0] c);
      if (lit_radix == RADIX_HEX) begin
         return is_dec_digit(c) || (c >= CH_UPPER_A && c <= CH_UPPER_F);
      end
      return is_oct_digit(c);
   endfunction

   function automatic bit is_sign(input logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS;
   endfunction

   // the count sticks at the limit and every byte past it marks overflow
   function automatic void count_lit_byte();
      if (lit_count < LIT_MAX) begin
         lit_count++;
      end else begin
         lit_over = 1'b1;
      end
   endfunction

   function automatic void clear_literal();
      lit_mode  = MODE_IDLE;
      lit_radix = RADIX_DEC;
      lit_count = 0;
      lit_over  = 1'b0;
   endfunction

   function automatic void push_result();
      literal_result_type r;
      case (lit_mode)
         MODE_DEC_FRAC, MODE_DEC_ESIGN, MODE_DEC_EXP,
         MODE_PFX_FRAC, MODE_PFX_ESIGN, MODE_PFX_EXP: r.kind = KIND_FLOAT;
         default: r.kind = KIND_INT;
      endcase
      r.radix    = lit_radix;
      r.length   = (lit_count > 255) ? 8'd255 : 8'(lit_count);
      r.too_long = lit_over;
      expected_literals.push_back(r);
   endfunction

   // start a literal; a byte that cannot begin one leaves the scanner idle
   function automatic bit open_literal(input logic [7:0] c);
      clear_literal();
      if (c == CH_ZERO) begin
         lit_mode = MODE_ZERO;
      end else if (is_dec_digit(c)) begin
         lit_mode = MODE_DEC_INT;
      end else if (c == CH_DOT) begin
         lit_mode = MODE_DEC_FRAC;
      end else begin
         return 1'b0;
      end
      count_lit_byte();
      return 1'b1;
   endfunction

   // where byte c takes the literal; MODE_IDLE means c ends it
   function automatic scan_mode_type next_lit_mode(input logic [7:0] c);
      case (lit_mode)
         MODE_ZERO: begin
            if (c == CH_LOWER_B) begin
               lit_radix = RADIX_BIN;
               return MODE_BIN;
            end
            if (c == CH_UNDERSCORE) begin
               lit_radix = RADIX_OCT;
               return MODE_PFX_INT;
            end
            if (c == CH_LOWER_X) begin
               lit_radix = RADIX_HEX;
               return MODE_PFX_INT;
            end
            if (is_dec_digit(c)) return MODE_DEC_INT;
            if (c == CH_DOT) return MODE_DEC_FRAC;
            return MODE_IDLE;
         end
         MODE_BIN: return (c == CH_ZERO || c == CH_ONE) ? MODE_BIN : MODE_IDLE;
         MODE_DEC_INT: begin
            if (is_dec_digit(c)) return MODE_DEC_INT;
            return (c == CH_DOT) ? MODE_DEC_FRAC : MODE_IDLE;
         end
         MODE_DEC_FRAC: begin
            if (is_dec_digit(c)) return MODE_DEC_FRAC;
            return (c == CH_LOWER_P) ? MODE_DEC_ESIGN : MODE_IDLE;
         end
         // decimal exponent digits are octal
         MODE_DEC_ESIGN: return (is_sign(c) || is_oct_digit(c)) ? MODE_DEC_EXP : MODE_IDLE;
         MODE_DEC_EXP: return is_oct_digit(c) ? MODE_DEC_EXP : MODE_IDLE;
         MODE_PFX_INT: begin
            if (is_radix_digit(c)) return MODE_PFX_INT;
            if (c == CH_DOT) return MODE_PFX_FRAC;
            if (c == CH_LOWER_P) return MODE_PFX_ESIGN;
            return (c == CH_UPPER_S) ? MODE_SUFFIXED : MODE_IDLE;
         end
         MODE_PFX_FRAC: begin
            if (is_radix_digit(c)) return MODE_PFX_FRAC;
            return (c == CH_LOWER_P) ? MODE_PFX_ESIGN : MODE_IDLE;
         end
         MODE_PFX_ESIGN: return (is_sign(c) || is_radix_digit(c)) ? MODE_PFX_EXP : MODE_IDLE;
         MODE_PFX_EXP: return is_radix_digit(c) ? MODE_PFX_EXP : MODE_IDLE;
         // a suffixed literal is complete, anything ends it
         default: return MODE_IDLE;
      endcase
   endfunction

   // follow one accepted item; returns 0 when the scanner ignores it
   function automatic bit scan_byte(input logic [7:0] c, input logic s);
      scan_mode_type nxt;
      if (lit_mode == MODE_IDLE) begin
         if (!s) return 1'b0;
         // a start byte that begins nothing gives the empty literal
         if (!open_literal(c)) push_result();
         return 1'b1;
      end
      if (s) begin
         // the running literal ends; an empty new one is dropped quietly
         push_result();
         void'(open_literal(c));
         return 1'b1;
      end
      nxt = next_lit_mode(c);
      if (nxt == MODE_IDLE) begin
         push_result();
         clear_literal();
      end else begin
         lit_mode = nxt;
         count_lit_byte();
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // result side: random back pressure and the compare
   // ---------------------------------------------------------------------------

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         sink_pick = (sink_stalls && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_ready  <= (sink_pick == 0);
         stall_left <= (sink_pick > 0) ? sink_pick - 1 : 0;
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_literals.size() == 0) begin
            $display({"%0t: result with none expected, actual kind %0d radix %0d",
                      " length %0d too_long %0d"},
                     $time, rsp_token_kind, rsp_radix, rsp_length, rsp_too_long);
            error_count++;
         end else begin
            want_lit = expected_literals.pop_front();
            check_field("token_kind", 8'(want_lit.kind), 8'(rsp_token_kind));
            check_field("radix", 8'(want_lit.radix), 8'(rsp_radix));
            check_field("length", want_lit.length, rsp_length);
            check_field("too_long", 8'(want_lit.too_long), 8'(rsp_too_long));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // byte source
   // ---------------------------------------------------------------------------

   // one item through the req handshake, then into the predictor
   task automatic send_byte(input logic [7:0] c, input logic s);
      int gap;
      gap = source_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_ch        <= c;
      req_start_req <= s;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (scan_byte(c, s)) bytes_scanned++;
   endtask

   // first character carries the start flag
   task automatic send_text(input string txt);
      for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == 0);
   endtask

   // sender holds off until every owed result is out, then lets the pipe settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_literals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_digit(input logic [1:0] rdx);
      int d;
      case (rdx)
         RADIX_BIN: d = $urandom_range(0, 1);
         RADIX_OCT: d = $urandom_range(0, 7);
         RADIX_HEX: d = $urandom_range(0, 15);
         default:   d = $urandom_range(0, 9);
      endcase
      return (d < 10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d - 10);
   endfunction

   // digit runs are mostly short, a few longer
   function automatic int pick_len();
      return ($urandom_range(0, 9) != 0) ? $urandom_range(0, 5) : $urandom_range(6, 30);
   endfunction

   // now and then a byte inside a literal is replaced by a random one
   task automatic send_lit_byte(input logic [7:0] c, input logic s);
      if ($urandom_range(0, 39) == 0) begin
         send_byte(8'($urandom_range(0, 255)), s);
      end else begin
         send_byte(c, s);
      end
   endtask

   task automatic send_digits(input logic [1:0] rdx, input int n);
      for (int i = 0; i < n; i++) send_lit_byte(pick_digit(rdx), 1'b0);
   endtask

   task automatic send_exponent(input logic [1:0] rdx);
      send_lit_byte(CH_LOWER_P, 1'b0);
      case ($urandom_range(0, 2))
         0: send_lit_byte(CH_PLUS, 1'b0);
         1: send_lit_byte(CH_MINUS, 1'b0);
         default: ;
      endcase
      send_digits(rdx, pick_len());
   endtask

   // one well-formed literal with random content and a random ending
   task automatic send_random_literal();
      int form;
      logic [1:0] rdx;
      bit has_frac;
      bit has_exp;
      form     = $urandom_range(0, 9);
      has_frac = ($urandom_range(0, 2) == 0);
      has_exp  = ($urandom_range(0, 2) == 0);
      if (form < 6) begin
         // prefixed forms: binary, octal, hex
         rdx = (form < 2) ? RADIX_BIN : (form < 4) ? RADIX_OCT : RADIX_HEX;
         send_lit_byte(CH_ZERO, 1'b1);
         send_lit_byte((rdx == RADIX_BIN) ? CH_LOWER_B :
                       (rdx == RADIX_OCT) ? CH_UNDERSCORE : CH_LOWER_X, 1'b0);
         send_digits(rdx, pick_len());
         if (rdx != RADIX_BIN) begin
            if (has_frac) begin
               send_lit_byte(CH_DOT, 1'b0);
               send_digits(rdx, pick_len());
            end
            if (has_exp) begin
               send_exponent(rdx);
            end else if (!has_frac && $urandom_range(0, 2) == 0) begin
               send_lit_byte(CH_UPPER_S, 1'b0);
            end
         end
      end else begin
         // decimal, with a leading digit or a leading point
         if (form == 9) begin
            send_lit_byte(CH_DOT, 1'b1);
         end else begin
            send_lit_byte(pick_digit(RADIX_DEC), 1'b1);
            send_digits(RADIX_DEC, pick_len());
            if (has_frac) send_lit_byte(CH_DOT, 1'b0);
         end
         if (form == 9 || has_frac) begin
            send_digits(RADIX_DEC, pick_len());
            if (has_exp) send_exponent(RADIX_OCT);
         end
      end
      // ending: a stray byte, the next start, a random start byte, or noise
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: send_byte(8'($urandom_range(0, 255)), 1'b0);
         5, 6: ;
         7: send_byte(8'($urandom_range(0, 255)), 1'b1);
         default: begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   task automatic test_directed();
      send_byte(8'hFF, 1'b0);     // idle and no start: ignored
      send_byte(8'h00, 1'b1);     // start byte that begins nothing: empty literal
      send_byte(8'hFF, 1'b1);
      send_text("0 ");            // lone zero
      send_text("0b101 ");
      send_text("0x ");           // prefix with no body
      send_text("0x1F.Ap+E ");
      send_text("0_17S7");        // after the suffix even a digit ends it
      send_text("0_p ");          // exponent with no digits
      send_text("9.5p-7 ");
      send_text(".8p3 ");
      send_text("12");
      send_text("34");            // start while scanning
      send_text("z");             // start while scanning, nothing new begins
   endtask

   // lengths around the saturation point of the byte count
   task automatic test_long_literals();
      int sizes[4] = '{LIT_MAX - 1, LIT_MAX, LIT_MAX + 1, LIT_MAX + 45};
      foreach (sizes[k]) begin
         send_byte(CH_ONE, 1'b1);
         for (int i = 1; i < sizes[k]; i++) send_byte(pick_digit(RADIX_DEC), 1'b0);
         send_byte(CH_SPACE, 1'b0);
      end
   endtask

   task automatic test_random_stream();
      int goal;
      // idle gaps on both sides
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
      goal = bytes_scanned + RANDOM_BYTES / 2;
      while (bytes_scanned < goal) send_random_literal();
      send_byte(CH_SPACE, 1'b0);
      wait_for_drain();
      // back to back, no idling anywhere
      source_gaps = 1'b0;
      sink_stalls = 1'b0;
      goal = bytes_scanned + RANDOM_BYTES / 4;
      while (bytes_scanned < goal) send_random_literal();
      send_byte(CH_SPACE, 1'b0);
      wait_for_drain();
      // full-rate source against a stalling sink
      sink_stalls = 1'b1;
      goal = bytes_scanned + RANDOM_BYTES / 4;
      while (bytes_scanned < goal) send_random_literal();
      send_byte(CH_SPACE, 1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      source_gaps = 1'b1;
      test_directed();
      test_long_literals();
      test_random_stream();
      wait_for_drain();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #(4_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/nls_pkg.sv
rtl/nls_front.sv
rtl/nls_queue.sv
rtl/nls_back.sv
rtl/number_literal_scanner_top.sv
verif/tb.sv
